FILE: hw/rtl/qsdk_pkg.sv
// ----------------------------------------------------------------------------
// Quintic spline delta kernel package
// Shared widths, fixed-point constants, piece codes and Horner coefficients.
// ----------------------------------------------------------------------------
package qsdk_pkg;

  localparam int FRAC_BITS = 16;

  localparam int COORD_W = 32;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 64;
  localparam int R_W     = 32;
  localparam int ACC_W   = 35;
  localparam int MAG_W   = ACC_W - 1;
  localparam int PHI_W   = 31;
  localparam int W_W     = 32;
  localparam int Q_FRAC  = 30;

  localparam int PROD_FRAC = 2 * FRAC_BITS;
  localparam int R_SHR = (PROD_FRAC >= Q_FRAC) ? PROD_FRAC - Q_FRAC : 0;
  localparam int R_SHL = (PROD_FRAC >= Q_FRAC) ? 0 : Q_FRAC - PROD_FRAC;

  localparam logic [PROD_W-1:0] SUPPORT_LIMIT = PROD_W'(3) << PROD_FRAC;
  localparam logic [R_W-1:0]    Q30_ONE       = R_W'(1) << Q_FRAC;
  localparam logic [R_W-1:0]    Q30_TWO       = R_W'(2) << Q_FRAC;
  localparam logic [CFG_W-1:0]  CFG_ONE       = CFG_W'(1) << FRAC_BITS;

  localparam int FRONT_STAGES   = 3;
  localparam int HORNER_STEPS   = 5;
  localparam int COMBINE_STAGES = 2;
  localparam int NUM_STAGES     = FRONT_STAGES + HORNER_STEPS + COMBINE_STAGES;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INV_SPACING    = 2'd0,
    REG_INV_SPACING_SQ = 2'd1
  } reg_idx_e;

  typedef enum logic [1:0] {
    PIECE_INNER = 2'd0,
    PIECE_MID   = 2'd1,
    PIECE_OUTER = 2'd2
  } piece_e;

  typedef struct packed {
    logic signed [ACC_W-1:0] acc;
    logic [R_W-1:0]          r;
    piece_e                  piece;
    logic                    in_range;
  } axis_t;

  typedef logic signed [ACC_W-1:0] coef_row_t [6];

  localparam coef_row_t PIECE0 = '{
    -35'sd89478485, 35'sd268435456, 35'sd0,
    -35'sd536870912, 35'sd0, 35'sd590558003
  };
  localparam coef_row_t PIECE1 = '{
    35'sd44739243, -35'sd402653184, 35'sd1342177280,
    -35'sd1879048192, 35'sd671088640, 35'sd456340275
  };
  localparam coef_row_t PIECE2 = '{
    -35'sd8947849, 35'sd134217728, -35'sd805306368,
    35'sd2415919104, -35'sd3623878656, 35'sd2174327194
  };

  function automatic logic signed [ACC_W-1:0] coef(piece_e p, logic [2:0] idx);
    logic signed [ACC_W-1:0] c;
    c = '0;
    if (idx < 3'd6) begin
      case (p)
        PIECE_INNER: c = PIECE0[idx];
        PIECE_MID:   c = PIECE1[idx];
        PIECE_OUTER: c = PIECE2[idx];
        default:     c = '0;
      endcase
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/qsdk_ifs.sv
// ----------------------------------------------------------------------------
// Quintic spline delta kernel channels
// Valid/ready channels for the point pair items and the weight result items.
// ----------------------------------------------------------------------------
interface qsdk_in_if import qsdk_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_a_x;
  logic signed [COORD_W-1:0] point_a_y;
  logic signed [COORD_W-1:0] point_b_x;
  logic signed [COORD_W-1:0] point_b_y;

  modport source (output valid, point_a_x, point_a_y, point_b_x, point_b_y, input ready);
  modport sink   (input valid, point_a_x, point_a_y, point_b_x, point_b_y, output ready);
endinterface

interface qsdk_out_if import qsdk_pkg::*;;
  logic           valid;
  logic           ready;
  logic [W_W-1:0] weight;
  logic           in_support;

  modport source (output valid, weight, in_support, input ready);
  modport sink   (input valid, weight, in_support, output ready);
endinterface

FILE: hw/rtl/qsdk_axis_front.sv
// ----------------------------------------------------------------------------
// Axis front end
// Three stages: absolute difference, scaling by the inverse spacing, and the
// support test with the choice of polynomial piece.
// ----------------------------------------------------------------------------
module qsdk_axis_front import qsdk_pkg::*; (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [COORD_W-1:0] a_i,
  input  logic signed [COORD_W-1:0] b_i,
  input  logic [CFG_W-1:0]          inv_spacing_i,
  output axis_t                     axis_o
);

  logic signed [DIFF_W-1:0]   diff;
  logic [DIFF_W-1:0]          mag_d, mag_q;
  logic [DIFF_W+CFG_W-1:0]    full;
  logic [PROD_W-1:0]          prod_d, prod_q;
  logic [R_W-1:0]             r;
  axis_t                      axis_d, axis_q;

  always_comb begin
    diff  = DIFF_W'(a_i) - DIFF_W'(b_i);
    mag_d = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  end

  always_comb begin
    full   = (DIFF_W+CFG_W)'(mag_q) * (DIFF_W+CFG_W)'(inv_spacing_i);
    prod_d = full[PROD_W-1:0];
  end

  always_comb begin
    r = R_W'((prod_q >> R_SHR) << R_SHL);
    axis_d.r        = r;
    axis_d.in_range = prod_q < SUPPORT_LIMIT;
    if (r < Q30_ONE) begin
      axis_d.piece = PIECE_INNER;
    end else if (r < Q30_TWO) begin
      axis_d.piece = PIECE_MID;
    end else begin
      axis_d.piece = PIECE_OUTER;
    end
    axis_d.acc = coef(axis_d.piece, 3'd0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q  <= mag_d;
      prod_q <= prod_d;
      axis_q <= axis_d;
    end
  end

  assign axis_o = axis_q;

endmodule

FILE: hw/rtl/qsdk_horner_step.sv
// ----------------------------------------------------------------------------
// Horner step
// One registered step of the polynomial: multiply by r, round to nearest with
// ties away from zero, and add the next coefficient of the selected piece.
// ----------------------------------------------------------------------------
module qsdk_horner_step import qsdk_pkg::*; (
  input  logic       clk_i,
  input  logic       en_i,
  input  logic [2:0] coef_idx_i,
  input  axis_t      axis_i,
  output axis_t      axis_o
);

  logic                    neg;
  logic [MAG_W-1:0]        mag;
  logic [MAG_W+R_W-1:0]    full;
  logic [MAG_W+R_W-1:0]    rnd;
  logic signed [ACC_W-1:0] p;
  logic signed [ACC_W-1:0] pn;
  axis_t                   axis_d, axis_q;

  always_comb begin
    neg  = axis_i.acc[ACC_W-1];
    mag  = neg ? MAG_W'(-axis_i.acc) : MAG_W'(axis_i.acc);
    full = (MAG_W+R_W)'(mag) * (MAG_W+R_W)'(axis_i.r);
    rnd  = (full + (MAG_W+R_W)'(1 << (Q_FRAC - 1))) >> Q_FRAC;
    p    = ACC_W'(rnd);
    pn   = neg ? -p : p;
    axis_d        = axis_i;
    axis_d.acc    = pn + coef(axis_i.piece, coef_idx_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      axis_q <= axis_d;
    end
  end

  assign axis_o = axis_q;

endmodule

FILE: hw/rtl/qsdk_combine.sv
// ----------------------------------------------------------------------------
// Axis combiner
// Clamps both axis values, forms their product in Q1.30 and scales it by the
// inverse spacing squared with saturation, over two stages.
// ----------------------------------------------------------------------------
module qsdk_combine import qsdk_pkg::*; (
  input  logic           clk_i,
  input  logic           en_i,
  input  axis_t          x_i,
  input  axis_t          y_i,
  input  logic [CFG_W-1:0] inv_spacing_sq_i,
  output logic [W_W-1:0] weight_o,
  output logic           in_support_o
);

  logic [PHI_W-1:0]         phi_x, phi_y;
  logic [2*PHI_W-1:0]       pp;
  logic [PHI_W-1:0]         prod_d, prod_q;
  logic                     sup_d, sup_q;
  logic [PHI_W+CFG_W-1:0]   wf;
  logic [PHI_W+CFG_W-1:0]   wr;
  logic [W_W-1:0]           weight_d, weight_q;
  logic                     out_sup_q;

  always_comb begin
    phi_x  = (x_i.in_range && !x_i.acc[ACC_W-1]) ? PHI_W'(x_i.acc) : '0;
    phi_y  = (y_i.in_range && !y_i.acc[ACC_W-1]) ? PHI_W'(y_i.acc) : '0;
    pp     = (2*PHI_W)'(phi_x) * (2*PHI_W)'(phi_y);
    prod_d = PHI_W'((pp + (2*PHI_W)'(1 << (Q_FRAC - 1))) >> Q_FRAC);
    sup_d  = x_i.in_range && y_i.in_range;
  end

  always_comb begin
    wf = (PHI_W+CFG_W)'(prod_q) * (PHI_W+CFG_W)'(inv_spacing_sq_i);
    wr = (wf + (PHI_W+CFG_W)'(1 << (Q_FRAC - 1))) >> Q_FRAC;
    weight_d = (|wr[PHI_W+CFG_W-1:W_W]) ? '1 : wr[W_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q    <= prod_d;
      sup_q     <= sup_d;
      weight_q  <= weight_d;
      out_sup_q <= sup_q;
    end
  end

  assign weight_o     = weight_q;
  assign in_support_o = out_sup_q;

endmodule

FILE: hw/rtl/quintic_spline_delta_kernel_2d_unit.sv
// ----------------------------------------------------------------------------
// Quintic spline delta kernel, 2-D
// Immersed-boundary interpolation weight between two Q16.16 points.
//
//   Channel  Dir  Handshake     Payload
//   pt_i     in   valid/ready   point_a_x, point_a_y, point_b_x, point_b_y
//   res_o    out  valid/ready   weight, in_support
//   cfg      in   cfg_we_i      cfg_idx_i, cfg_wdata_i
//
// One item enters per cycle while the output is not stalled, and passes three
// front stages per axis, five Horner multiply stages, two combining stages.
// All stages advance together whenever the output register is empty or its
// item is being taken, so a stall holds every item in place.
// Reset clears the valid bits and sets both registers to 1.0.
// ----------------------------------------------------------------------------
module quintic_spline_delta_kernel_2d_unit import qsdk_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  qsdk_in_if.sink              pt_i,
  qsdk_out_if.source           res_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  logic [CFG_W-1:0]      inv_spacing_q, inv_spacing_sq_q;
  logic [NUM_STAGES-1:0] vld_d, vld_q;
  logic                  adv;
  axis_t                 hx [HORNER_STEPS+1];
  axis_t                 hy [HORNER_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_spacing_q    <= CFG_ONE;
      inv_spacing_sq_q <= CFG_ONE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_INV_SPACING:    inv_spacing_q    <= cfg_wdata_i;
        REG_INV_SPACING_SQ: inv_spacing_sq_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign adv       = !vld_q[NUM_STAGES-1] || res_o.ready;
  assign pt_i.ready = adv;
  assign vld_d     = {vld_q[NUM_STAGES-2:0], pt_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  qsdk_axis_front u_front_x (
    .clk_i         (clk_i),
    .en_i          (adv),
    .a_i           (pt_i.point_a_x),
    .b_i           (pt_i.point_b_x),
    .inv_spacing_i (inv_spacing_q),
    .axis_o        (hx[0])
  );

  qsdk_axis_front u_front_y (
    .clk_i         (clk_i),
    .en_i          (adv),
    .a_i           (pt_i.point_a_y),
    .b_i           (pt_i.point_b_y),
    .inv_spacing_i (inv_spacing_q),
    .axis_o        (hy[0])
  );

  for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_horner
    qsdk_horner_step u_step_x (
      .clk_i      (clk_i),
      .en_i       (adv),
      .coef_idx_i (3'(k + 1)),
      .axis_i     (hx[k]),
      .axis_o     (hx[k+1])
    );
    qsdk_horner_step u_step_y (
      .clk_i      (clk_i),
      .en_i       (adv),
      .coef_idx_i (3'(k + 1)),
      .axis_i     (hy[k]),
      .axis_o     (hy[k+1])
    );
  end

  qsdk_combine u_combine (
    .clk_i            (clk_i),
    .en_i             (adv),
    .x_i              (hx[HORNER_STEPS]),
    .y_i              (hy[HORNER_STEPS]),
    .inv_spacing_sq_i (inv_spacing_sq_q),
    .weight_o         (res_o.weight),
    .in_support_o     (res_o.in_support)
  );

  assign res_o.valid = vld_q[NUM_STAGES-1];

  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.in_support |-> res_o.weight == '0)
    else $error("Weight is non-zero outside the support.");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pt_i.valid && pt_i.ready |=> vld_q[0])
    else $error("Accepted item did not enter the first stage.");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("Pipeline valid bits moved during a stall.");

endmodule

FILE: test/quintic_spline_delta_kernel_2d_unit_tb.sv
// ----------------------------------------------------------------------------
// Quintic spline delta kernel, 2-D: regression bench
// Streams point pairs through the kernel unit under random source gaps and
// sink stalls. Every accepted pair is scored by a fixed-point model of the
// quintic B-spline weight, and each result is checked against it in order.
// The spacing registers are retuned between bursts, including zero and
// full-scale settings and writes to unused register indexes.
// ----------------------------------------------------------------------------
module quintic_spline_delta_kernel_2d_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import qsdk_pkg::*;

  localparam int FRAC = FRAC_BITS;
  localparam int DIST_SHR = (2 * FRAC >= 30) ? 2 * FRAC - 30 : 0;
  localparam int DIST_SHL = (2 * FRAC >= 30) ? 0 : 30 - 2 * FRAC;
  localparam bit [63:0] UNIT_Q30 = 64'd1 << 30;
  localparam bit [63:0] HALF_Q30 = 64'd1 << 29;
  localparam longint COORD_MAX = 64'sd2147483647;
  localparam longint COORD_MIN = -64'sd2147483648;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int DRAIN_CYCLES = 24;

  localparam longint SPLINE_COEF [3][6] = '{
    '{-64'sd89478485, 64'sd268435456, 64'sd0,
      -64'sd536870912, 64'sd0, 64'sd590558003},
    '{64'sd44739243, -64'sd402653184, 64'sd1342177280,
      -64'sd1879048192, 64'sd671088640, 64'sd456340275},
    '{-64'sd8947849, 64'sd134217728, -64'sd805306368,
      64'sd2415919104, -64'sd3623878656, 64'sd2174327194}
  };

  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
  } pair_t;

  typedef struct packed {
    logic [W_W-1:0] weight;
    logic           in_support;
  } kernel_result_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;

  qsdk_in_if  pt_if ();
  qsdk_out_if res_if ();

  quintic_spline_delta_kernel_2d_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pt_i        (pt_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  pair_t          point_queue [$];
  kernel_result_t pending_weights [$];
  logic [CFG_W-1:0] inv_h = 32'h0001_0000;
  logic [CFG_W-1:0] inv_h_sq = 32'h0001_0000;
  int  points_queued = 0;
  int  points_accepted = 0;
  int  errors = 0;
  int  src_wait = 0;
  int  snk_wait = 0;
  bit  src_calm = 1'b0;
  bit  snk_calm = 1'b0;
  bit  pt_taken = 1'b0;
  bit  res_taken = 1'b0;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic longint scale_by_r(longint a, bit [63:0] r);
    bit [63:0] m;
    bit [63:0] p;
    m = (a < 0) ? 64'(-a) : 64'(a);
    p = (m * r + HALF_Q30) >> 30;
    return (a < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic bit [63:0] spline_phi(logic signed [COORD_W-1:0] a,
                                           logic signed [COORD_W-1:0] b,
                                           logic [CFG_W-1:0] scale,
                                           output bit in_range);
    longint    d;
    longint    acc;
    bit [63:0] mag;
    bit [63:0] scaled;
    bit [63:0] r;
    piece_e    seg;
    d = longint'(a) - longint'(b);
    mag = (d < 0) ? 64'(-d) : 64'(d);
    scaled = mag * {32'd0, scale};
    if (scaled >= (64'd3 << (2 * FRAC))) begin
      in_range = 1'b0;
      return 64'd0;
    end
    in_range = 1'b1;
    r = (scaled >> DIST_SHR) << DIST_SHL;
    if (r < UNIT_Q30) seg = PIECE_INNER;
    else if (r < 2 * UNIT_Q30) seg = PIECE_MID;
    else seg = PIECE_OUTER;
    acc = SPLINE_COEF[int'(seg)][0];
    for (int i = 1; i < 6; i++) begin
      acc = scale_by_r(acc, r) + SPLINE_COEF[int'(seg)][i];
    end
    return (acc < 0) ? 64'd0 : 64'(acc);
  endfunction

  function automatic kernel_result_t kernel_weight(pair_t p);
    kernel_result_t res;
    bit [63:0] phi_x;
    bit [63:0] phi_y;
    bit [63:0] prod;
    bit [63:0] w;
    bit in_x;
    bit in_y;
    phi_x = spline_phi(p.ax, p.bx, inv_h, in_x);
    phi_y = spline_phi(p.ay, p.by, inv_h, in_y);
    prod = (phi_x * phi_y + HALF_Q30) >> 30;
    w = (prod * {32'd0, inv_h_sq} + HALF_Q30) >> 30;
    if (w > 64'hFFFF_FFFF) w = 64'hFFFF_FFFF;
    res.weight = w[W_W-1:0];
    res.in_support = in_x & in_y;
    return res;
  endfunction

  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic pair_t mk(logic signed [COORD_W-1:0] ax, logic signed [COORD_W-1:0] ay,
                               logic signed [COORD_W-1:0] bx, logic signed [COORD_W-1:0] by);
    pair_t p;
    p.ax = ax;
    p.ay = ay;
    p.bx = bx;
    p.by = by;
    return p;
  endfunction

  // Most pairs lie within about four spacings so that all three spline pieces are reached.
  function automatic void random_axis(logic [CFG_W-1:0] scale,
                                      output logic signed [COORD_W-1:0] a,
                                      output logic signed [COORD_W-1:0] b);
    bit [63:0] reach;
    bit [63:0] span;
    longint    d;
    longint    other;
    a = $urandom;
    if ($urandom_range(0, 7) == 0) begin
      b = $urandom;
      return;
    end
    reach = (scale == '0) ? (64'd1 << 32) : (64'd4 << 32) / scale;
    if (reach > (64'd1 << 32)) reach = 64'd1 << 32;
    span = {$urandom, $urandom} % (2 * reach + 1);
    d = longint'(span) - longint'(reach);
    other = longint'(a) - d;
    if (other > COORD_MAX) other = COORD_MAX;
    if (other < COORD_MIN) other = COORD_MIN;
    b = other[COORD_W-1:0];
  endfunction

  task automatic send(pair_t p);
    point_queue.insert(point_queue.size(), p);
    points_queued++;
  endtask

  task automatic queue_random(int n, logic [CFG_W-1:0] scale);
    pair_t p;
    repeat (n) begin
      random_axis(scale, p.ax, p.bx);
      random_axis(scale, p.ay, p.by);
      send(p);
    end
  endtask

  task automatic wait_idle();
    while (points_accepted != points_queued || pending_weights.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic retune(logic [CFG_W-1:0] inv, logic [CFG_W-1:0] inv_sq);
    wait_idle();
    write_reg(REG_INV_SPACING, inv);
    write_reg(REG_INV_SPACING_SQ, inv_sq);
  endtask

  always @(negedge clk_i) begin : point_driver
    pair_t p;
    logic  next_valid;
    if (!rst_ni) begin
      pt_if.valid <= 1'b0;
      pt_if.point_a_x <= '0;
      pt_if.point_a_y <= '0;
      pt_if.point_b_x <= '0;
      pt_if.point_b_y <= '0;
    end else begin
      next_valid = pt_if.valid;
      if (pt_taken) begin
        next_valid = 1'b0;
        pt_taken = 1'b0;
      end
      if (!next_valid) begin
        if (src_wait > 0) begin
          src_wait--;
        end else if (point_queue.size() != 0) begin
          p = point_queue.pop_front();
          pt_if.point_a_x <= p.ax;
          pt_if.point_a_y <= p.ay;
          pt_if.point_b_x <= p.bx;
          pt_if.point_b_y <= p.by;
          next_valid = 1'b1;
          src_wait = draw_wait(src_calm);
        end
      end
      pt_if.valid <= next_valid;
    end
  end

  always @(negedge clk_i) begin : result_sink
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_taken) begin
        res_taken = 1'b0;
        snk_wait = draw_wait(snk_calm);
      end
      if (snk_wait > 0) begin
        snk_wait--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : kernel_monitor
    kernel_result_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_INV_SPACING:    inv_h = cfg_wdata_i;
          REG_INV_SPACING_SQ: inv_h_sq = cfg_wdata_i;
          default:            ;
        endcase
      end
      if (pt_if.valid && pt_if.ready) begin
        pending_weights.insert(pending_weights.size(),
                               kernel_weight(mk(pt_if.point_a_x, pt_if.point_a_y,
                                                pt_if.point_b_x, pt_if.point_b_y)));
        points_accepted++;
        pt_taken = 1'b1;
      end
      if (res_if.valid && res_if.ready) begin
        res_taken = 1'b1;
        if (pending_weights.size() == 0) begin
          errors++;
          $display("%0t: unexpected item, expected none, actual weight %h in_support %b",
                   $time, res_if.weight, res_if.in_support);
        end else begin
          want = pending_weights.pop_front();
          if (res_if.weight !== want.weight) begin
            errors++;
            $display("%0t: weight mismatch, expected %h, actual %h",
                     $time, want.weight, res_if.weight);
          end
          if (res_if.in_support !== want.in_support) begin
            errors++;
            $display("%0t: in_support mismatch, expected %b, actual %b",
                     $time, want.in_support, res_if.in_support);
          end
        end
      end
    end
  end

  initial begin
    #600000;
    $display("quintic_spline_delta_kernel_2d_unit regression: fail");
    $finish;
  end

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Registers at their reset value of 1.0: piece boundaries, the support edge and extremes.
    send(mk(32'sh0, 32'sh0, 32'sh0, 32'sh0));
    send(mk(32'sh10000, 32'sh0, 32'sh0, 32'sh0));
    send(mk(32'sh20000, 32'sh0, 32'sh0, 32'sh0));
    send(mk(32'sh2FFFF, 32'sh0, 32'sh0, 32'sh1FFFF));
    send(mk(32'sh30000, 32'sh0, 32'sh0, 32'sh0));
    send(mk(32'sh0, -32'sh30000, 32'sh0, 32'sh0));
    send(mk(32'sh40000, 32'sh30000, 32'sh0, 32'sh0));
    send(mk(32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF));
    send(mk(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF));
    send(mk(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000));
    send(mk(32'sh18000, 32'sh0, 32'sh0, 32'sh28000));
    send(mk(32'sh0FFFF, 32'sh1FFFF, 32'sh0, 32'sh0));
    send(mk(-32'sh1, 32'sh0, 32'sh0, 32'sh1));
    send(mk(32'sh12345678, -32'sh01234567, 32'sh12345678 - 32'sh8000,
            -32'sh01234567 + 32'sh24000));
    send(mk(32'shFFFF0000, 32'sh00010000, 32'sh00010000, 32'shFFFF0000));
    queue_random(150, 32'h0001_0000);

    // Full-scale spacing: a few ulps span the whole support, and the weight peaks.
    retune(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(mk(32'sh5, 32'sh5, 32'sh5, 32'sh5));
    send(mk(32'sh1, 32'sh0, 32'sh0, 32'sh2));
    send(mk(32'sh3, 32'sh0, 32'sh0, 32'sh4));
    send(mk(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000));
    queue_random(70, 32'hFFFF_FFFF);

    retune(32'h0000_0001, 32'h0004_0000);
    queue_random(60, 32'h0000_0001);

    retune(32'h0004_0000, 32'h0010_0000);
    queue_random(60, 32'h0004_0000);

    // Zero both, then inv_sq to 1.0; writes to unused indexes must leave both alone.
    retune(32'h0000_0000, 32'h0000_0000);
    queue_random(20, 32'h0000_0000);
    wait_idle();
    write_reg(REG_INV_SPACING_SQ, 32'h0001_0000);
    write_reg(REG_SPARE_A, $urandom);
    write_reg(REG_SPARE_B, $urandom);
    queue_random(20, 32'h0000_0000);

    for (int k = 0; k < 3; k++) begin
      logic [CFG_W-1:0] inv;
      inv = $urandom_range(32'h0000_4000, 32'h0008_0000);
      retune(inv, $urandom);
      queue_random(50, inv);
    end
    begin
      logic [CFG_W-1:0] inv;
      inv = $urandom;
      retune(inv, $urandom);
      queue_random(50, inv);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0) begin
      $display("quintic_spline_delta_kernel_2d_unit regression: pass");
    end else begin
      $display("quintic_spline_delta_kernel_2d_unit regression: fail");
    end
    $finish;
  end

endmodule
